@@ src/sbt_pkg.sv @@
// Shared types and constants for the sorted block table.
// No dependencies; imported by sorted_block_table_top.
package sbt_pkg;

  localparam int TableDepth = 64;
  localparam int AddrBits   = 20;
  localparam int OwnerBits  = 16;
  localparam int IdxBits    = $clog2(TableDepth);
  localparam int CntBits    = IdxBits + 1;
  localparam int SizeBits   = AddrBits + 1;

  localparam logic [1:0] CmdInsert   = 2'd0;
  localparam logic [1:0] CmdRemove   = 2'd1;
  localparam logic [1:0] CmdFind     = 2'd2;
  localparam logic [1:0] CmdCoalesce = 2'd3;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StEmpty    = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  localparam logic [1:0] ModeAscSize  = 2'd1;
  localparam logic [1:0] ModeDescSize = 2'd2;

  typedef struct packed {
    logic [OwnerBits-1:0] owner;
    logic [AddrBits-1:0]  start;
    logic [AddrBits-1:0]  last;
  } entry_t;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_SC_RD  = 15'b000000000000010,
    S_SC_CK  = 15'b000000000000100,
    S_SH_RD  = 15'b000000000001000,
    S_SH_WR  = 15'b000000000010000,
    S_RM_RD  = 15'b000000000100000,
    S_RM_CAP = 15'b000000001000000,
    S_MV_RD  = 15'b000000010000000,
    S_MV_WR  = 15'b000000100000000,
    S_FD_RD  = 15'b000001000000000,
    S_FD_CK  = 15'b000010000000000,
    S_CO_RD0 = 15'b000100000000000,
    S_CO_LD  = 15'b001000000000000,
    S_CO_RD  = 15'b010000000000000,
    S_CO_CK  = 15'b100000000000000
  } state_e;

  function automatic logic [SizeBits-1:0] blk_size(logic [AddrBits-1:0] s,
                                                    logic [AddrBits-1:0] e);
    return {1'b0, e} + SizeBits'(1) - {1'b0, s};
  endfunction

endpackage

@@ src/sorted_block_table_top.sv @@
// Sorted block table: ordered table of address blocks with insert, remove,
// first-fit search and coalesce. Depends on sbt_pkg.
//
// One command is taken at a time and walks the table entry by entry through
// an entry memory with one read port, one write port and registered read
// data. For n stored entries, insert scans up to n entries, reading then
// checking each, and shifts the tail, reading then writing each entry;
// remove shifts the tail; find scans until the first fit; coalesce walks
// all n entries. The result waits in an output register; the next command
// is accepted once it is taken. order_mode may be written whenever the
// block is idle.
module sorted_block_table_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // owner_id[15:0], start_addr[35:16], end_addr[55:36], entry_index[61:56],
  // req_size[82:62], zero fill above
  input  logic [87:0]         s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_index[5:0], out_owner[21:6], out_start[41:22], out_end[61:42],
  // entry_count[68:62], zero fill above
  output logic [71:0]         m_axis_tdata,
  // status[1:0]
  output logic [1:0]          m_axis_tuser,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_data
);
  import sbt_pkg::*;

  entry_t mem [TableDepth];
  entry_t rdata_q, wdata;
  logic   we;
  logic [IdxBits-1:0] waddr, raddr;

  state_e state_q, state_d;
  logic [1:0] mode_q;
  logic [CntBits-1:0] used_q, used_d, ptr_q, ptr_d, pos_q, pos_d, keep_q, keep_d;
  entry_t new_q, new_d, acc_q, acc_d;
  logic [SizeBits-1:0] req_q, req_d;
  logic ovalid_q, ovalid_d;
  logic [1:0] ost_q, ost_d;
  logic [IdxBits-1:0] oidx_q, oidx_d;
  entry_t oent_q, oent_d;
  logic [CntBits-1:0] ocnt_q, ocnt_d;

  logic [SizeBits-1:0] nsz, csz;
  logic stop;
  logic [CntBits-1:0] ptr_m1, ptr_p1;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = ost_q;
  assign m_axis_tdata  = {3'b0, ocnt_q, oent_q.last, oent_q.start, oent_q.owner, oidx_q};

  assign nsz    = blk_size(new_q.start, new_q.last);
  assign csz    = blk_size(rdata_q.start, rdata_q.last);
  assign ptr_m1 = ptr_q - CntBits'(1);
  assign ptr_p1 = ptr_q + CntBits'(1);

  always_comb begin
    case (mode_q)
      ModeAscSize:  stop = nsz < csz;
      ModeDescSize: stop = nsz > csz;
      default:      stop = rdata_q.start >= new_q.start;
    endcase
  end

  always_comb begin
    case (state_q)
      S_SH_RD: raddr = ptr_m1[IdxBits-1:0];
      S_MV_RD: raddr = ptr_p1[IdxBits-1:0];
      default: raddr = ptr_q[IdxBits-1:0];
    endcase
  end

  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    ptr_d    = ptr_q;
    pos_d    = pos_q;
    keep_d   = keep_q;
    new_d    = new_q;
    acc_d    = acc_q;
    req_d    = req_q;
    ovalid_d = ovalid_q;
    ost_d    = ost_q;
    oidx_d   = oidx_q;
    oent_d   = oent_q;
    ocnt_d   = ocnt_q;
    we       = 1'b0;
    waddr    = ptr_q[IdxBits-1:0];
    wdata    = rdata_q;
    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          new_d.owner = s_axis_tdata[15:0];
          new_d.start = s_axis_tdata[35:16];
          new_d.last  = s_axis_tdata[55:36];
          req_d       = s_axis_tdata[82:62];
          ost_d       = StOk;
          oidx_d      = '0;
          oent_d      = '0;
          ocnt_d      = used_q;
          ptr_d       = '0;
          case (s_axis_tuser)
            CmdInsert: begin
              if (used_q == CntBits'(TableDepth)) begin
                ost_d = StFull; ovalid_d = 1'b1;
              end else begin
                state_d = S_SC_RD;
              end
            end
            CmdRemove: begin
              if (used_q == '0) begin
                ost_d = StEmpty; ovalid_d = 1'b1;
              end else if ({1'b0, s_axis_tdata[61:56]} >= used_q) begin
                ost_d = StNotFound; ovalid_d = 1'b1;
              end else begin
                ptr_d = {1'b0, s_axis_tdata[61:56]};
                state_d = S_RM_RD;
              end
            end
            CmdFind: begin
              if (used_q == '0) begin
                ost_d = StEmpty; ovalid_d = 1'b1;
              end else begin
                state_d = S_FD_RD;
              end
            end
            default: begin
              if (used_q == '0) begin
                ost_d = StEmpty; ovalid_d = 1'b1;
              end else begin
                state_d = S_CO_RD0;
              end
            end
          endcase
        end
      end
      S_SC_RD: begin
        if (ptr_q == used_q) begin
          pos_d = ptr_q; ptr_d = used_q; state_d = S_SH_RD;
        end else begin
          state_d = S_SC_CK;
        end
      end
      S_SC_CK: begin
        if (stop) begin
          pos_d = ptr_q; ptr_d = used_q; state_d = S_SH_RD;
        end else begin
          ptr_d = ptr_p1; state_d = S_SC_RD;
        end
      end
      S_SH_RD: begin
        if (ptr_q == pos_q) begin
          we = 1'b1; wdata = new_q;
          used_d = used_q + CntBits'(1);
          ocnt_d = used_d; ovalid_d = 1'b1; state_d = S_IDLE;
        end else begin
          state_d = S_SH_WR;
        end
      end
      S_SH_WR: begin
        // shift the entry read from ptr-1 up into ptr
        we = 1'b1; ptr_d = ptr_m1; state_d = S_SH_RD;
      end
      S_RM_RD: state_d = S_RM_CAP;
      S_RM_CAP: begin
        oidx_d = ptr_q[IdxBits-1:0]; oent_d = rdata_q; state_d = S_MV_RD;
      end
      S_MV_RD: begin
        if (ptr_p1 >= used_q) begin
          used_d = used_q - CntBits'(1);
          ocnt_d = used_d; ovalid_d = 1'b1; state_d = S_IDLE;
        end else begin
          state_d = S_MV_WR;
        end
      end
      S_MV_WR: begin
        we = 1'b1; ptr_d = ptr_p1; state_d = S_MV_RD;
      end
      S_FD_RD: begin
        if (ptr_q == used_q) begin
          ost_d = StNotFound; ovalid_d = 1'b1; state_d = S_IDLE;
        end else begin
          state_d = S_FD_CK;
        end
      end
      S_FD_CK: begin
        if (req_q <= csz) begin
          oidx_d = ptr_q[IdxBits-1:0]; oent_d = rdata_q;
          ovalid_d = 1'b1; state_d = S_IDLE;
        end else begin
          ptr_d = ptr_p1; state_d = S_FD_RD;
        end
      end
      S_CO_RD0: state_d = S_CO_LD;
      S_CO_LD: begin
        acc_d = rdata_q; keep_d = '0; ptr_d = CntBits'(1); state_d = S_CO_RD;
      end
      S_CO_RD: begin
        if (ptr_q == used_q) begin
          we = 1'b1; waddr = keep_q[IdxBits-1:0]; wdata = acc_q;
          used_d = keep_q + CntBits'(1);
          ocnt_d = used_d; ovalid_d = 1'b1; state_d = S_IDLE;
        end else begin
          state_d = S_CO_CK;
        end
      end
      S_CO_CK: begin
        // end + 1 is formed one bit wider, so an all-ones end never merges
        if (({1'b0, acc_q.last} + SizeBits'(1)) == {1'b0, rdata_q.start}) begin
          acc_d.last = rdata_q.last;
        end else begin
          we = 1'b1; waddr = keep_q[IdxBits-1:0]; wdata = acc_q;
          keep_d = keep_q + CntBits'(1);
          acc_d = rdata_q;
        end
        ptr_d = ptr_p1; state_d = S_CO_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    pos_q  <= pos_d;
    keep_q <= keep_d;
    new_q  <= new_d;
    acc_q  <= acc_d;
    req_q  <= req_d;
    ost_q  <= ost_d;
    oidx_q <= oidx_d;
    oent_q <= oent_d;
    ocnt_q <= ocnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      ovalid_q <= 1'b0;
      mode_q   <= '0;
    end else begin
      state_q  <= state_d;
      used_q   <= used_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid && cfg_ready) mode_q <= cfg_data;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CntBits'(TableDepth)) else $error("entry count above depth");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == S_IDLE) else $error("ready while busy");

  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && state_q == S_IDLE) |-> ocnt_q == used_q)
    else $error("reported count differs from table");

  a_full_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CmdInsert &&
     used_q == CntBits'(TableDepth)) |=> used_q == $past(used_q))
    else $error("full insert changed table");

endmodule
